[hdl/ehc_pkg.sv]
// ----------------------------------------------------------------------------
// ehc_pkg: shared types, constants and helpers
// Widths, Magnus fixed-point constants, the 2^(k/16) table and one restoring
// divide step used by both divider pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

package ehc_pkg;

  localparam int TEMP_W = 15;
  localparam int RH_W   = 14;
  localparam int EQ_W   = 16;
  localparam int GAP_W  = 17;

  // Magnus coefficient 17.62*log2(e) in Q16, and 243.12 / 273.15 in hundredths
  localparam int MAGNUS_K = 1665944;
  localparam int MAGNUS_B = 24312;
  localparam int KELVIN   = 27315;

  localparam int DIV_W   = 16;               // divisor and remainder width
  localparam int PROD_W  = 36;               // |t| * MAGNUS_K
  localparam int LOG_QW  = 22;               // quotient bits of g(t)
  localparam int G_W     = LOG_QW + 1;       // signed g(t)
  localparam int Z_W     = G_W + 1;          // signed exponent difference
  localparam int LOG_LAT = LOG_QW + 2;

  localparam int EXP_RANGE = 20;
  localparam int EXP_LIM   = EXP_RANGE * 65536;
  localparam int E_W       = 6;              // integer exponent + EXP_RANGE

  localparam int M_W    = 18;                // mantissa 2^f in Q16
  localparam int P3_W   = RH_W + M_W;
  localparam int NUM_W  = 48;
  localparam int WIDE_W = NUM_W + EXP_RANGE - 1;
  localparam int SCALE_LAT = 5;

  localparam int RDIV_QW  = 32;
  localparam int DIV_LAT  = RDIV_QW + 2;
  localparam int CORE_LAT = LOG_LAT + SCALE_LAT + DIV_LAT;

  typedef struct packed {
    logic zero;
    logic sat;
  } ehc_flags_t;

  typedef struct packed {
    logic              fault;
    logic [RH_W-1:0]   irh;
  } side_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] ti;
    logic signed [TEMP_W-1:0] te;
    logic [RH_W-1:0]          erh;
  } temp_side_t;

  function automatic logic [M_W-1:0] pow2_q16(input logic [4:0] k);
    logic [M_W-1:0] v;
    case (k)
      5'd0:  v = 18'd65536;
      5'd1:  v = 18'd68438;
      5'd2:  v = 18'd71468;
      5'd3:  v = 18'd74632;
      5'd4:  v = 18'd77936;
      5'd5:  v = 18'd81386;
      5'd6:  v = 18'd84990;
      5'd7:  v = 18'd88752;
      5'd8:  v = 18'd92682;
      5'd9:  v = 18'd96785;
      5'd10: v = 18'd101070;
      5'd11: v = 18'd105545;
      5'd12: v = 18'd110218;
      5'd13: v = 18'd115098;
      5'd14: v = 18'd120194;
      5'd15: v = 18'd125515;
      5'd16: v = 18'd131072;
      default: v = '0;
    endcase
    return v;
  endfunction

  // one restoring step: returns {quotient bit, new remainder}; rem < d on entry
  function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
                                              input logic b,
                                              input logic [DIV_W-1:0] d);
    logic [DIV_W:0] t;
    logic [DIV_W:0] diff;
    t    = {rem, b};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {1'b1, diff[DIV_W-1:0]};
    end
    return {1'b0, t[DIV_W-1:0]};
  endfunction

endpackage

`default_nettype wire

[hdl/ehc_magnus_log.sv]
// ----------------------------------------------------------------------------
// ehc_magnus_log: Magnus exponent in log2 units
// g(t) = trunc(t * K / (B + t)), Q16; one multiply stage, a one-bit-per-stage
// restoring divider on the magnitude, and a sign fix stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ehc_magnus_log (
  input  logic                              clk,
  input  logic signed [ehc_pkg::TEMP_W-1:0] t,
  output logic signed [ehc_pkg::G_W-1:0]    g
);
  import ehc_pkg::*;

  logic [TEMP_W-1:0]     t_mag;
  logic [PROD_W-1:0]     prod;
  logic [DIV_W-1:0]      den;
  logic [DIV_W-1:0]      rem_r [0:LOG_QW];
  logic [LOG_QW-1:0]     x_r   [0:LOG_QW];
  logic [DIV_W-1:0]      den_r [0:LOG_QW];
  logic                  neg_r [0:LOG_QW];
  logic signed [G_W-1:0] q_ext;
  logic signed [G_W-1:0] g_r;

  assign t_mag = t[TEMP_W-1] ? TEMP_W'(-t) : TEMP_W'(t);
  assign prod  = PROD_W'(t_mag) * PROD_W'(MAGNUS_K);
  assign den   = DIV_W'(MAGNUS_B + int'(t));

  always_ff @(posedge clk) begin
    rem_r[0] <= DIV_W'(prod[PROD_W-1:LOG_QW]);
    x_r[0]   <= prod[LOG_QW-1:0];
    den_r[0] <= den;
    neg_r[0] <= t[TEMP_W-1];
  end

  for (genvar s = 0; s < LOG_QW; s++) begin : g_div
    logic [DIV_W:0] st;
    assign st = div_step(rem_r[s], x_r[s][LOG_QW-1], den_r[s]);
    always_ff @(posedge clk) begin
      rem_r[s+1] <= st[DIV_W-1:0];
      x_r[s+1]   <= {x_r[s][LOG_QW-2:0], st[DIV_W]};
      den_r[s+1] <= den_r[s];
      neg_r[s+1] <= neg_r[s];
    end
  end

  assign q_ext = signed'(G_W'(x_r[LOG_QW]));

  always_ff @(posedge clk) begin
    g_r <= neg_r[LOG_QW] ? -q_ext : q_ext;
  end

  assign g = g_r;

endmodule

`default_nettype wire

[hdl/ehc_scale.sv]
// ----------------------------------------------------------------------------
// ehc_scale: exponent split, 2^f interpolation and numerator build
// Five stages: classify/split, mantissa, rh*m, *Ki, shift by the integer
// exponent. Out: shifted numerator, Ke and zero/saturate flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ehc_scale (
  input  logic                              clk,
  input  logic signed [ehc_pkg::G_W-1:0]    gi,
  input  logic signed [ehc_pkg::G_W-1:0]    ge,
  input  logic signed [ehc_pkg::TEMP_W-1:0] ti,
  input  logic signed [ehc_pkg::TEMP_W-1:0] te,
  input  logic [ehc_pkg::RH_W-1:0]          erh,
  output logic [ehc_pkg::NUM_W-1:0]         num,
  output logic [ehc_pkg::DIV_W-1:0]         ke,
  output ehc_pkg::ehc_flags_t               flags
);
  import ehc_pkg::*;

  logic signed [Z_W-1:0] z;
  logic [Z_W-1:0]        u;
  logic                  big;
  logic                  tiny;
  logic                  rh0;

  logic [3:0]       k1_r;
  logic [11:0]      w1_r;
  logic [E_W-1:0]   e1_r, e2_r, e3_r, e4_r;
  logic [RH_W-1:0]  rh1_r, rh2_r;
  logic [DIV_W-1:0] ki1_r, ki2_r, ki3_r;
  logic [DIV_W-1:0] ke1_r, ke2_r, ke3_r, ke4_r, ke5_r;
  ehc_flags_t       fl1_r, fl2_r, fl3_r, fl4_r, fl5_r;

  logic [M_W-1:0]   p_lo, p_hi, p_diff, m;
  logic [29:0]      iprod;
  logic [M_W-1:0]   m2_r;
  logic [P3_W-1:0]  p3_r;
  logic [NUM_W-1:0] n4_r;
  logic [NUM_W-1:0] num5_r;

  logic [E_W-1:0]    rs, ls;
  logic [WIDE_W-1:0] wide;
  logic              ovf;
  logic [NUM_W-1:0]  shifted;

  // stage 1: exponent difference and range split
  assign z    = $signed({ge[G_W-1], ge}) - $signed({gi[G_W-1], gi});
  assign big  = z >= EXP_LIM;
  assign tiny = z < -EXP_LIM;
  assign rh0  = (erh == '0);
  assign u    = Z_W'(z + EXP_LIM);

  always_ff @(posedge clk) begin
    k1_r       <= u[15:12];
    w1_r       <= u[11:0];
    e1_r       <= u[E_W+15:16];
    rh1_r      <= erh;
    ki1_r      <= DIV_W'(KELVIN + int'(ti));
    ke1_r      <= DIV_W'(KELVIN + int'(te));
    fl1_r.zero <= rh0 | tiny;
    fl1_r.sat  <= ~rh0 & big;
  end

  // stage 2: mantissa by table plus linear interpolation
  assign p_lo   = pow2_q16({1'b0, k1_r});
  assign p_hi   = pow2_q16({1'b0, k1_r} + 5'd1);
  assign p_diff = p_hi - p_lo;
  assign iprod  = 30'(p_diff) * 30'(w1_r) + 30'd2048;
  assign m      = p_lo + M_W'(iprod[29:12]);

  always_ff @(posedge clk) begin
    m2_r  <= m;
    e2_r  <= e1_r;
    rh2_r <= rh1_r;
    ki2_r <= ki1_r;
    ke2_r <= ke1_r;
    fl2_r <= fl1_r;
  end

  // stage 3/4: rh * m * Ki
  always_ff @(posedge clk) begin
    p3_r  <= P3_W'(rh2_r) * P3_W'(m2_r);
    e3_r  <= e2_r;
    ki3_r <= ki2_r;
    ke3_r <= ke2_r;
    fl3_r <= fl2_r;
  end

  always_ff @(posedge clk) begin
    n4_r  <= NUM_W'(p3_r) * NUM_W'(ki3_r);
    e4_r  <= e3_r;
    ke4_r <= ke3_r;
    fl4_r <= fl3_r;
  end

  // stage 5: scale by 2^n; anything past 48 bits is certain overflow
  assign rs   = E_W'(EXP_RANGE) - e4_r;
  assign ls   = e4_r - E_W'(EXP_RANGE);
  assign wide = WIDE_W'(n4_r) << ls;

  always_comb begin
    if (e4_r < E_W'(EXP_RANGE)) begin
      shifted = n4_r >> rs;
      ovf     = 1'b0;
    end else begin
      shifted = wide[NUM_W-1:0];
      ovf     = |wide[WIDE_W-1:NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    num5_r     <= shifted;
    ke5_r      <= ke4_r;
    fl5_r.zero <= fl4_r.zero;
    fl5_r.sat  <= fl4_r.sat | ovf;
  end

  assign num   = num5_r;
  assign ke    = ke5_r;
  assign flags = fl5_r;

endmodule

`default_nettype wire

[hdl/ehc_ratio_div.sv]
// ----------------------------------------------------------------------------
// ehc_ratio_div: rounded quotient num / (65536 * Ke)
// Top-half overflow check, 32 restoring steps, then round half up with
// clipping to 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ehc_ratio_div (
  input  logic                      clk,
  input  logic [ehc_pkg::NUM_W-1:0] num,
  input  logic [ehc_pkg::DIV_W-1:0] ke,
  input  ehc_pkg::ehc_flags_t       flags,
  output logic [ehc_pkg::EQ_W-1:0]  eq,
  output logic                      sat
);
  import ehc_pkg::*;

  logic [DIV_W-1:0]   hi;
  logic               pre;
  logic [DIV_W-1:0]   rem_r [0:RDIV_QW];
  logic [RDIV_QW-1:0] x_r   [0:RDIV_QW];
  logic [DIV_W-1:0]   ke_r  [0:RDIV_QW];
  ehc_flags_t         fl_r  [0:RDIV_QW];
  logic [RDIV_QW:0]   rnd;
  logic               sat_f;
  logic [EQ_W-1:0]    eq_r;
  logic               sat_r;

  // quotient >= 2^32 already clips
  assign hi  = num[NUM_W-1:RDIV_QW];
  assign pre = hi >= ke;

  always_ff @(posedge clk) begin
    rem_r[0]     <= pre ? '0 : hi;
    x_r[0]       <= num[RDIV_QW-1:0];
    ke_r[0]      <= ke;
    fl_r[0].zero <= flags.zero;
    fl_r[0].sat  <= flags.sat | pre;
  end

  for (genvar s = 0; s < RDIV_QW; s++) begin : g_div
    logic [DIV_W:0] st;
    assign st = div_step(rem_r[s], x_r[s][RDIV_QW-1], ke_r[s]);
    always_ff @(posedge clk) begin
      rem_r[s+1] <= st[DIV_W-1:0];
      x_r[s+1]   <= {x_r[s][RDIV_QW-2:0], st[DIV_W]};
      ke_r[s+1]  <= ke_r[s];
      fl_r[s+1]  <= fl_r[s];
    end
  end

  assign rnd   = {1'b0, x_r[RDIV_QW]} + (RDIV_QW+1)'(32768);
  assign sat_f = fl_r[RDIV_QW].sat | rnd[RDIV_QW];

  always_ff @(posedge clk) begin
    if (fl_r[RDIV_QW].zero) begin
      eq_r  <= '0;
      sat_r <= 1'b0;
    end else if (sat_f) begin
      eq_r  <= '1;
      sat_r <= 1'b1;
    end else begin
      eq_r  <= rnd[RDIV_QW-1:RDIV_QW-EQ_W];
      sat_r <= 1'b0;
    end
  end

  assign eq  = eq_r;
  assign sat = sat_r;

endmodule

`default_nettype wire

[hdl/equivalent_humidity_compare_core.sv]
// ----------------------------------------------------------------------------
// equivalent_humidity_compare_core: exterior RH re-expressed at interior temp
// Throughput: one request per cycle; busy never rises (no stalls).
// Depth is set by the two restoring dividers (22 and 32 steps).
// Reset clears the valid pipeline and out_strobe; data registers are not reset.
// Results appear for one cycle and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module equivalent_humidity_compare_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [ehc_pkg::TEMP_W-1:0] in_int_temp,
  input  logic [ehc_pkg::RH_W-1:0]          in_int_rh,
  input  logic                              in_int_fault,
  input  logic signed [ehc_pkg::TEMP_W-1:0] in_ext_temp,
  input  logic [ehc_pkg::RH_W-1:0]          in_ext_rh,
  input  logic                              in_ext_fault,
  output logic                              out_strobe,
  output logic [ehc_pkg::EQ_W-1:0]          out_equiv_rh,
  output logic signed [ehc_pkg::GAP_W-1:0]  out_rh_gap,
  output logic                              out_result_valid,
  output logic                              out_saturated
);
  import ehc_pkg::*;

  logic                  accept;
  logic [CORE_LAT-1:0]   vld_r;
  side_t                 side_r  [0:CORE_LAT-1];
  temp_side_t            tside_r [0:LOG_LAT-1];

  logic signed [G_W-1:0] gi, ge;
  logic [NUM_W-1:0]      num;
  logic [DIV_W-1:0]      ke;
  ehc_flags_t            flags;
  logic [EQ_W-1:0]       eq;
  logic                  sat;
  side_t                 side_end;

  logic                    out_strobe_r;
  logic [EQ_W-1:0]         out_equiv_rh_r;
  logic signed [GAP_W-1:0] out_rh_gap_r;
  logic                    out_result_valid_r;
  logic                    out_saturated_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[CORE_LAT-2:0], accept};
    end
  end

  // request sideband travels beside the datapath
  always_ff @(posedge clk) begin
    side_r[0].fault <= in_int_fault | in_ext_fault;
    side_r[0].irh   <= in_int_rh;
    tside_r[0].ti   <= in_int_temp;
    tside_r[0].te   <= in_ext_temp;
    tside_r[0].erh  <= in_ext_rh;
    for (int i = 1; i < CORE_LAT; i++) begin
      side_r[i] <= side_r[i-1];
    end
    for (int i = 1; i < LOG_LAT; i++) begin
      tside_r[i] <= tside_r[i-1];
    end
  end

  ehc_magnus_log u_log_int (
    .clk (clk),
    .t   (in_int_temp),
    .g   (gi)
  );

  ehc_magnus_log u_log_ext (
    .clk (clk),
    .t   (in_ext_temp),
    .g   (ge)
  );

  ehc_scale u_scale (
    .clk   (clk),
    .gi    (gi),
    .ge    (ge),
    .ti    (tside_r[LOG_LAT-1].ti),
    .te    (tside_r[LOG_LAT-1].te),
    .erh   (tside_r[LOG_LAT-1].erh),
    .num   (num),
    .ke    (ke),
    .flags (flags)
  );

  ehc_ratio_div u_div (
    .clk   (clk),
    .num   (num),
    .ke    (ke),
    .flags (flags),
    .eq    (eq),
    .sat   (sat)
  );

  assign side_end = side_r[CORE_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= vld_r[CORE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (side_end.fault) begin
      out_equiv_rh_r     <= '0;
      out_rh_gap_r       <= '0;
      out_result_valid_r <= 1'b0;
      out_saturated_r    <= 1'b0;
    end else begin
      out_equiv_rh_r     <= eq;
      out_rh_gap_r       <= $signed({3'b000, side_end.irh}) - $signed({1'b0, eq});
      out_result_valid_r <= 1'b1;
      out_saturated_r    <= sat;
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_equiv_rh     = out_equiv_rh_r;
  assign out_rh_gap       = out_rh_gap_r;
  assign out_result_valid = out_result_valid_r;
  assign out_saturated    = out_saturated_r;

endmodule

`default_nettype wire
